// ===== hdl/ets_pkg.sv =====
// Package: widths, word types and back-end state codes for event time statistics.
package ets_pkg;

  localparam int unsigned MAX_HITS  = 256;
  localparam int unsigned TIME_BITS = 24;
  localparam int unsigned TW        = 24;   // time field width
  localparam int unsigned CW        = 9;    // hit count width
  localparam int unsigned SUMW      = 32;
  localparam int unsigned SQW       = 54;
  localparam int unsigned RMSW      = 23;
  localparam int unsigned TSHIFT    = TW - TIME_BITS;
  localparam logic [CW-1:0]  MAX_CNT = CW'(MAX_HITS);
  localparam logic [SQW-1:0] SQ_MAX  = {SQW{1'b1}};
  localparam logic [SQW-1:0] SQRT_BIT0 = SQW'(1) << (SQW - 2);

  typedef struct packed {
    logic signed [TW-1:0] hit_time;
    logic                 last_of_event;
    logic                 no_hits;
  } in_word_t;

  typedef struct packed {
    logic signed [TW-1:0] first_time;
    logic signed [TW-1:0] final_time;
    logic signed [TW-1:0] mean_time;
    logic [RMSW-1:0]      rms_time;
    logic [CW-1:0]        hit_count;
    logic                 empty_event;
    logic                 too_many_hits;
  } out_word_t;

  // Per-event totals handed from front to back.
  typedef struct packed {
    logic signed [TW-1:0]   min_t;
    logic signed [TW-1:0]   max_t;
    logic signed [SUMW-1:0] sum;
    logic [SQW-1:0]         sq_sum;
    logic [CW-1:0]          cnt;
    logic                   ovf;
  } evt_rec_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_DONE
  } bk_state_t;

endpackage

// ===== hdl/ets_front.sv =====
// Front end: accumulates hit statistics and emits one totals record per event.
module ets_front
  import ets_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  in_word_t word,
  output logic     rec_push,
  output evt_rec_t rec
);

  logic signed [TW-1:0]   min_r, max_r;
  logic signed [SUMW-1:0] sum_r;
  logic [SQW-1:0]         sq_r;
  logic [CW-1:0]          cnt_r;
  logic                   ovf_r;

  logic signed [TW-1:0]   t;
  logic [2*TW-1:0]        sq;
  logic [SQW:0]           sq_add;
  logic                   hit;
  evt_rec_t               upd;

  assign t      = $signed(word.hit_time <<< TSHIFT) >>> TSHIFT;
  assign sq     = $unsigned((2*TW)'(t) * (2*TW)'(t));
  assign sq_add = {1'b0, sq_r} + (SQW+1)'(sq);
  assign hit    = acc && !word.no_hits && (cnt_r < MAX_CNT);

  always_comb begin
    upd.min_t  = min_r;
    upd.max_t  = max_r;
    upd.sum    = sum_r;
    upd.sq_sum = sq_r;
    upd.cnt    = cnt_r;
    upd.ovf    = ovf_r || (acc && !word.no_hits && (cnt_r >= MAX_CNT));
    if (hit) begin
      upd.min_t  = (cnt_r == '0 || t < min_r) ? t : min_r;
      upd.max_t  = (cnt_r == '0 || t > max_r) ? t : max_r;
      upd.sum    = sum_r + SUMW'(t);
      upd.sq_sum = sq_add[SQW] ? SQ_MAX : sq_add[SQW-1:0];
      upd.cnt    = cnt_r + 1'b1;
    end
  end

  assign rec      = upd;
  assign rec_push = acc && word.last_of_event;

  always_ff @(posedge clk) begin
    if (!rst_n || rec_push) begin
      min_r <= '0;
      max_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (acc) begin
      min_r <= upd.min_t;
      max_r <= upd.max_t;
      sum_r <= upd.sum;
      sq_r  <= upd.sq_sum;
      cnt_r <= upd.cnt;
      ovf_r <= upd.ovf;
    end
  end

endmodule

// ===== hdl/ets_queue.sv =====
// Two-entry register queue of event totals between front and back.
module ets_queue
  import ets_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  evt_rec_t wdata,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output evt_rec_t rdata
);

  evt_rec_t   slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/ets_back.sv =====
// Back end: serial divides for mean and mean square, serial square root, result register.
module ets_back
  import ets_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  evt_rec_t  q_rdata,
  output logic      q_pop,
  output out_word_t out_word,
  output logic      out_empty,
  input  logic      out_pop
);

  bk_state_t      state_r, state_nxt;
  evt_rec_t       rec_r;
  logic [SQW-1:0] d_r, v_r, res_r, bit_r;
  logic [CW-1:0]  rem_r;
  logic [5:0]     step_r;
  logic           pass_r;
  logic [TW-1:0]  mean_r;
  out_word_t      ow_r;
  logic           ov_r;

  logic [CW:0]    r2, r2_sub;
  logic           ge;
  logic [SQW-1:0] d_step;
  logic [SQW:0]   rb;
  logic           sq_ge;
  logic [SUMW-1:0] mag;
  logic           take, load_out;

  // unsigned magnitude of the incoming sum (2^31 for the most negative sum)
  assign mag    = q_rdata.sum[SUMW-1] ? SUMW'(-q_rdata.sum) : SUMW'(q_rdata.sum);
  assign r2     = {rem_r, d_r[SQW-1]};
  assign r2_sub = r2 - {1'b0, rec_r.cnt};
  assign ge     = (r2 >= {1'b0, rec_r.cnt});
  assign d_step = {d_r[SQW-2:0], ge};
  assign rb     = {1'b0, res_r} + {1'b0, bit_r};
  assign sq_ge  = ({1'b0, v_r} >= rb);

  assign take     = (state_r == BK_IDLE) && !q_empty;
  assign load_out = (state_r == BK_DONE) && (!ov_r || out_pop);
  assign q_pop    = take;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (take) state_nxt = (q_rdata.cnt == '0) ? BK_DONE : BK_DIV;
      BK_DIV:  if (step_r == 6'(SQW - 1) && pass_r) state_nxt = BK_SQRT;
      BK_SQRT: if (bit_r[0]) state_nxt = BK_DONE;
      BK_DONE: if (load_out) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (take) begin
          rec_r  <= q_rdata;
          d_r    <= SQW'(mag);
          rem_r  <= '0;
          step_r <= '0;
          pass_r <= 1'b0;
        end
      end
      BK_DIV: begin
        if (step_r == 6'(SQW - 1)) begin
          step_r <= '0;
          rem_r  <= '0;
          if (!pass_r) begin
            mean_r <= rec_r.sum[SUMW-1] ? TW'(-d_step[TW-1:0]) : d_step[TW-1:0];
            d_r    <= rec_r.sq_sum;
            pass_r <= 1'b1;
          end else begin
            d_r   <= d_step;
            v_r   <= d_step;
            res_r <= '0;
            bit_r <= SQRT_BIT0;
          end
        end else begin
          rem_r  <= ge ? r2_sub[CW-1:0] : r2[CW-1:0];
          step_r <= step_r + 1'b1;
          d_r    <= d_step;
        end
      end
      BK_SQRT: begin
        if (sq_ge) begin
          v_r   <= v_r - rb[SQW-1:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      ow_r.too_many_hits <= rec_r.ovf;
      ow_r.hit_count     <= rec_r.cnt;
      if (rec_r.cnt == '0) begin
        ow_r.first_time  <= '0;
        ow_r.final_time  <= '0;
        ow_r.mean_time   <= '0;
        ow_r.rms_time    <= '0;
        ow_r.empty_event <= 1'b1;
      end else begin
        ow_r.first_time  <= rec_r.min_t;
        ow_r.final_time  <= rec_r.max_t;
        ow_r.mean_time   <= $signed(mean_r);
        ow_r.rms_time    <= (res_r > SQW'({RMSW{1'b1}})) ? {RMSW{1'b1}} : res_r[RMSW-1:0];
        ow_r.empty_event <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)        ov_r <= 1'b0;
    else if (load_out) ov_r <= 1'b1;
    else if (out_pop)  ov_r <= 1'b0;
  end

  assign out_word  = ow_r;
  assign out_empty = !ov_r;

endmodule

// ===== hdl/event_time_statistics.sv =====
// Top level: event time statistics (min, max, mean, RMS of hit times per event).
//
// Usage:
//  - Input queue port: in_word (hit_time Q15.8, last_of_event, no_hits), in_push, in_full.
//    A word is taken when in_push is high and in_full low. One word per hit;
//    the word with last_of_event closes the event. no_hits words add nothing.
//  - Result queue port: out_word, out_empty, out_pop. One result word per event,
//    valid while out_empty is low, taken when out_pop is high.
//  - Hits are accumulated one per cycle by the front end while in_full is low. Closing
//    an event hands its totals into a two-entry queue.
//  - The back end per event: take the totals, the mean divide, the mean-square divide
//    (restoring, one quotient bit a cycle), the square root (two bits of radicand a
//    cycle) and the result load. Empty events skip the divides and the square root.
//  - Sustained: one hit per cycle while in_full is low. The back end finishes one
//    event before it takes the totals of the next.
//  - in_full rises when the totals queue holds two events; a stalled result
//    receiver backs up into it, nothing is dropped.
//  - Synchronous reset clears the running totals, the queue pointers and count, and the
//    result valid flag (not the result word); out_empty is high after reset.
module event_time_statistics
  import ets_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  logic      in_push,
  output logic      in_full,
  output out_word_t out_word,
  output logic      out_empty,
  input  logic      out_pop
);

  logic     acc, rec_push, q_pop, q_empty;
  evt_rec_t rec, q_rdata;

  assign acc = in_push && !in_full;

  ets_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .word     (in_word),
    .rec_push (rec_push),
    .rec      (rec)
  );

  ets_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .wdata (rec),
    .full  (in_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  ets_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_word  (out_word),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  // Checks
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result visible after reset");
  a_empty_evt: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.empty_event) |-> (out_word.hit_count == '0 &&
      out_word.first_time == '0 && out_word.rms_time == '0))
    else $error("empty event with nonzero fields");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_word.hit_count <= MAX_CNT))
    else $error("hit count beyond limit");
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.too_many_hits) |-> (out_word.hit_count == MAX_CNT))
    else $error("overflow flagged below limit");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_word)))
    else $error("result changed while stalled");

endmodule
